// File: rtl/core/expf_pkg.sv
// ----------------------------------------------------------------------------
// expf_pkg
// Shared constants, types and the normalize/round helper for the
// binary32 multiply and add units of the exp pipeline.
// ----------------------------------------------------------------------------
package expf_pkg;

   localparam int FP_W = 32;
   localparam int SIG_W = 48;

   // binary32 constants
   localparam logic [FP_W-1:0] MAGIC_BIAS    = 32'h4B40_007F;
   localparam logic [FP_W-1:0] NEG_MAGIC     = 32'hCB40_007F;
   localparam logic [FP_W-1:0] DENORM_CUTOFF = 32'hC2AE_AC4F;
   localparam logic [FP_W-1:0] LOG2E         = 32'h3FB8_AA3B;
   localparam logic [FP_W-1:0] MINUS_LN2_HI  = 32'hBF31_7200;
   localparam logic [FP_W-1:0] MINUS_LN2_LO  = 32'hB5BF_BE8E;
   localparam logic [FP_W-1:0] C1            = 32'h3F7F_FFFB;
   localparam logic [FP_W-1:0] C2            = 32'h3EFF_FEE3;
   localparam logic [FP_W-1:0] C3            = 32'h3E2A_AD40;
   localparam logic [FP_W-1:0] C4            = 32'h3D2B_9D0D;
   localparam logic [FP_W-1:0] C5            = 32'h3C07_CFCE;

   localparam logic [FP_W-1:0] DEFAULT_NAN   = 32'hFFC0_0000;
   localparam logic [FP_W-1:0] QUIET_BIT     = 32'h0040_0000;
   localparam logic [30:0]     INF_MAG       = 31'h7F80_0000;

   // Unrounded intermediate: value = p * 2^(e - 173), or special bits.
   typedef struct packed {
      logic                   special;
      logic [FP_W-1:0]        spec_bits;
      logic                   sign;
      logic signed [11:0]     e;
      logic [SIG_W-1:0]       p;
   } norm_type;

   function automatic logic is_nan(input logic [FP_W-1:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [FP_W-1:0] v);
      return (v[30:0] == INF_MAG);
   endfunction

   function automatic logic [FP_W-1:0] norm_round(input norm_type v);
      logic [5:0]         lz;
      logic signed [11:0] lzs;
      logic signed [11:0] be;
      logic [11:0]        rs;
      logic [SIG_W-1:0]   q;
      logic               stk;
      logic               up;
      logic [30:0]        mag;
      logic [FP_W-1:0]    res;
      lz = 6'd48;
      for (int i = 0; i < SIG_W; i++) begin
         if (v.p[i]) lz = 6'(SIG_W - 1 - i);
      end
      lzs = $signed({6'd0, lz});
      stk = 1'b0;
      rs  = '0;
      if (lzs <= v.e) begin
         q = v.p << lz;
      end else if (v.e >= 12'sd0) begin
         // subnormal result, left shift limited by exponent
         q = v.p << v.e[5:0];
      end else begin
         rs = 12'(-v.e);
         if (rs >= 12'd48) begin
            q   = '0;
            stk = |v.p;
         end else begin
            q   = v.p >> rs[5:0];
            stk = |(v.p & ((48'd1 << rs[5:0]) - 48'd1));
         end
      end
      be  = q[47] ? (v.e + 12'sd1 - lzs) : 12'sd0;
      up  = q[23] & (stk | (|q[22:0]) | q[24]);
      mag = {be[7:0], q[46:24]} + 31'(up);
      if (be >= 12'sd255) res = {v.sign, 8'hFF, 23'd0};
      else                res = {v.sign, mag};
      return res;
   endfunction

endpackage

// File: rtl/core/expf_fmul.sv
// ----------------------------------------------------------------------------
// expf_fmul
// Two-stage binary32 multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module expf_fmul
   import expf_pkg::*;
(
   input  logic            clock,
   input  logic            enable,
   input  logic [FP_W-1:0] a_bits,
   input  logic [FP_W-1:0] b_bits,
   output logic [FP_W-1:0] r_bits
);

   norm_type        mid_in, mid_ff;
   logic [FP_W-1:0] r_in, r_ff;
   logic [7:0]      ea, eb;
   logic [23:0]     ma, mb;
   logic            a_zero, b_zero;

   always_comb begin
      ea     = (a_bits[30:23] == 8'd0) ? 8'd1 : a_bits[30:23];
      eb     = (b_bits[30:23] == 8'd0) ? 8'd1 : b_bits[30:23];
      ma     = {a_bits[30:23] != 8'd0, a_bits[22:0]};
      mb     = {b_bits[30:23] != 8'd0, b_bits[22:0]};
      a_zero = (a_bits[30:0] == 31'd0);
      b_zero = (b_bits[30:0] == 31'd0);

      mid_in.sign = a_bits[31] ^ b_bits[31];
      mid_in.e    = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd127;
      mid_in.p    = SIG_W'(ma) * SIG_W'(mb);
      mid_in.special   = 1'b1;
      mid_in.spec_bits = '0;
      if (is_nan(a_bits))
         mid_in.spec_bits = a_bits | QUIET_BIT;
      else if (is_nan(b_bits))
         mid_in.spec_bits = b_bits | QUIET_BIT;
      else if ((is_inf(a_bits) && b_zero) || (a_zero && is_inf(b_bits)))
         mid_in.spec_bits = DEFAULT_NAN;
      else if (is_inf(a_bits) || is_inf(b_bits))
         mid_in.spec_bits = {mid_in.sign, INF_MAG};
      else
         mid_in.special = 1'b0;
   end

   always_comb begin
      r_in = mid_ff.special ? mid_ff.spec_bits : norm_round(mid_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mid_ff <= mid_in;
         r_ff   <= r_in;
      end
   end

   assign r_bits = r_ff;

endmodule

// File: rtl/core/expf_fadd.sv
// ----------------------------------------------------------------------------
// expf_fadd
// Two-stage binary32 adder: align and add, then normalize and round.
// ----------------------------------------------------------------------------
module expf_fadd
   import expf_pkg::*;
(
   input  logic            clock,
   input  logic            enable,
   input  logic [FP_W-1:0] a_bits,
   input  logic [FP_W-1:0] b_bits,
   output logic [FP_W-1:0] r_bits
);

   norm_type        mid_in, mid_ff;
   logic [FP_W-1:0] r_in, r_ff;
   logic [FP_W-1:0] big, sml;
   logic [7:0]      e_big, e_sml, d;
   logic [26:0]     m_big, m_sml, al;
   logic            stk;
   logic [27:0]     sum;

   always_comb begin
      if (a_bits[30:0] >= b_bits[30:0]) begin
         big = a_bits;
         sml = b_bits;
      end else begin
         big = b_bits;
         sml = a_bits;
      end
      e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      m_big = {big[30:23] != 8'd0, big[22:0], 3'b000};
      m_sml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      d     = e_big - e_sml;
      if (d >= 8'd27) begin
         al  = '0;
         stk = |m_sml;
      end else begin
         al  = m_sml >> d[4:0];
         stk = |(m_sml & ((27'd1 << d[4:0]) - 27'd1));
      end
      al[0] = al[0] | stk;
      if (big[31] != sml[31]) sum = {1'b0, m_big} - {1'b0, al};
      else                    sum = {1'b0, m_big} + {1'b0, al};

      // exact zero: -0 only when both operands are -0
      mid_in.sign = (sum == 28'd0) ? (a_bits[31] & b_bits[31]) : big[31];
      mid_in.e    = $signed({4'd0, e_big});
      mid_in.p    = {sum, 20'd0};
      mid_in.special   = 1'b1;
      mid_in.spec_bits = '0;
      if (is_nan(a_bits))
         mid_in.spec_bits = a_bits | QUIET_BIT;
      else if (is_nan(b_bits))
         mid_in.spec_bits = b_bits | QUIET_BIT;
      else if (is_inf(a_bits) && is_inf(b_bits) && (a_bits[31] != b_bits[31]))
         mid_in.spec_bits = DEFAULT_NAN;
      else if (is_inf(a_bits))
         mid_in.spec_bits = a_bits;
      else if (is_inf(b_bits))
         mid_in.spec_bits = b_bits;
      else
         mid_in.special = 1'b0;
   end

   always_comb begin
      r_in = mid_ff.special ? mid_ff.spec_bits : norm_round(mid_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mid_ff <= mid_in;
         r_ff   <= r_in;
      end
   end

   assign r_bits = r_ff;

endmodule

// File: rtl/core/exp_negative_fp32_poly5_unit.sv
// ----------------------------------------------------------------------------
// exp_negative_fp32_poly5_unit
// Pipeline: an input register, then 18 chained binary32 operations of two
// stages each.
// Throughput: one request per cycle; the whole pipeline holds while the
// result is not taken.
// Reset clears only the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module exp_negative_fp32_poly5_unit
   import expf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [FP_W-1:0] req_x_bits,
   input  logic            req_in_last,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [FP_W-1:0] rsp_result_bits,
   output logic            rsp_out_last
);

   localparam int NumOps = 18;
   localparam int LastStg = 2 * NumOps;
   // operations that are multiplies (bit i-1 for operation i)
   localparam logic [NumOps-1:0] IsMul = 18'b01_1010_1010_1010_1001;

   typedef struct packed {
      logic            last;
      logic            cut;
      logic [FP_W-1:0] x;
      logic [FP_W-1:0] s;
      logic [FP_W-1:0] n;   // holds n, later the polynomial p
      logic [FP_W-1:0] t;
   } side_type;

   side_type        side_ff [0:LastStg];
   side_type        side_in [1:LastStg];
   logic [LastStg:0] valid_ff;
   logic            adv;
   logic            cut_in;
   logic [FP_W-1:0] op_a [1:NumOps];
   logic [FP_W-1:0] op_b [1:NumOps];
   logic [FP_W-1:0] op_r [1:NumOps];

   assign adv       = !valid_ff[LastStg] || rsp_ready;
   assign req_ready = adv && !reset;

   // x < cutoff, false for NaN
   assign cut_in = req_x_bits[31] && (req_x_bits[30:0] > DENORM_CUTOFF[30:0])
                   && (req_x_bits[30:0] <= INF_MAG);

   always_comb begin
      op_a[1]  = side_ff[0].x;    op_b[1]  = LOG2E;
      op_a[2]  = op_r[1];         op_b[2]  = MAGIC_BIAS;
      op_a[3]  = op_r[2];         op_b[3]  = NEG_MAGIC;
      op_a[4]  = op_r[3];         op_b[4]  = MINUS_LN2_HI;
      op_a[5]  = op_r[4];         op_b[5]  = side_ff[8].x;
      op_a[6]  = side_ff[10].n;   op_b[6]  = MINUS_LN2_LO;
      op_a[7]  = op_r[6];         op_b[7]  = side_ff[12].t;
      op_a[8]  = C5;              op_b[8]  = op_r[7];
      op_a[9]  = op_r[8];         op_b[9]  = C4;
      op_a[10] = op_r[9];         op_b[10] = side_ff[18].t;
      op_a[11] = op_r[10];        op_b[11] = C3;
      op_a[12] = op_r[11];        op_b[12] = side_ff[22].t;
      op_a[13] = op_r[12];        op_b[13] = C2;
      op_a[14] = op_r[13];        op_b[14] = side_ff[26].t;
      op_a[15] = op_r[14];        op_b[15] = C1;
      op_a[16] = side_ff[30].t;   op_b[16] = side_ff[30].s;
      op_a[17] = op_r[16];        op_b[17] = side_ff[32].n;
      op_a[18] = op_r[17];        op_b[18] = side_ff[34].s;
   end

   always_comb begin
      for (int k = 1; k <= LastStg; k++) side_in[k] = side_ff[k-1];
      side_in[5].s  = {op_r[2][8:0], 23'd0};   // scale 2^n from biased bits
      side_in[7].n  = op_r[3];
      side_in[11].t = op_r[5];
      side_in[15].t = op_r[7];
      side_in[31].n = op_r[15];
   end

   for (genvar i = 1; i <= NumOps; i++) begin : g_op
      if (IsMul[i-1]) begin : g_mul
         expf_fmul u_mul (
            .clock  (clock),
            .enable (adv),
            .a_bits (op_a[i]),
            .b_bits (op_b[i]),
            .r_bits (op_r[i])
         );
      end else begin : g_add
         expf_fadd u_add (
            .clock  (clock),
            .enable (adv),
            .a_bits (op_a[i]),
            .b_bits (op_b[i]),
            .r_bits (op_r[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LastStg-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].last <= req_in_last;
         side_ff[0].cut  <= cut_in;
         side_ff[0].x    <= req_x_bits;
         side_ff[0].s    <= '0;
         side_ff[0].n    <= '0;
         side_ff[0].t    <= '0;
         for (int k = 1; k <= LastStg; k++) side_ff[k] <= side_in[k];
      end
   end

   assign rsp_valid       = valid_ff[LastStg];
   assign rsp_result_bits = side_ff[LastStg].cut ? '0 : op_r[NumOps];
   assign rsp_out_last    = side_ff[LastStg].last;

endmodule
